[rtl/skt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sorted key table.
// Used by skt_ctrl, skt_dp, sorted_key_table, skt_checker and testbench; depends on nothing.
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // capture the transaction, start the search
    logic            rd_mid;    // read the search midpoint
    logic            step;      // narrow the search from the read key
    logic            rd_pos;    // read the entry at the search result
    logic            sh_init;   // set the shift pointer
    logic            rd_src;    // read the entry that moves next
    logic            wr_shift;  // write the moved entry, advance the pointer
    logic            wr_new;    // write the new entry at its position
    logic            fin;       // load the result register
    logic [ST_W-1:0] fin_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_lkp;
    logic full;
    logic srch_done;
    logic pos_valid;
    logic hit;
    logic sh_more;
  } sts_t;

endpackage

[rtl/sorted_key_table.sv]
`timescale 1ns / 1ps
// Top level of the sorted key table: ascending key store with insert, delete
// and lookup. Depends on skt_pkg, skt_ctrl and skt_dp.
//
//   channel | direction | handshake             | fields
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o | opcode_i, key_i, payload_i
//   out     | output    | out_valid_o/out_stall_i | status_o, found_payload_o,
//           |           |                       | found_index_o, entry_count_o
//
// One transaction at a time. The binary search takes a read and a compare state per halving
// step over the single-port entry memory, up to ceil(log2(count+1)) steps.
// An insert or delete then shifts entries one at a time: an insert moves every entry
// from its position up by one place, a delete moves every later entry down one.
// A full table or unused opcode skips the search and goes straight to the result.
// Reset clears the entry count; memory contents need no clearing.
// A finished result waits in the output register while the next transaction
// runs; that transaction holds in its last cycle until the register frees up.
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [skt_pkg::OP_W-1:0]  opcode_i,
  input  logic [skt_pkg::KEY_W-1:0] key_i,
  input  logic [skt_pkg::PAY_W-1:0] payload_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [skt_pkg::ST_W-1:0]  status_o,
  output logic [skt_pkg::PAY_W-1:0] found_payload_o,
  output logic [skt_pkg::IDX_W-1:0] found_index_o,
  output logic [skt_pkg::CNT_W-1:0] entry_count_o
);

  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .status_o        (status_o),
    .found_payload_o (found_payload_o),
    .found_index_o   (found_index_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

[rtl/skt_dp.sv]
`timescale 1ns / 1ps
// Datapath of the sorted key table: entry memory, search bounds, shift pointer,
// entry count and result register. Depends on skt_pkg.
module skt_dp #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skt_pkg::cmd_t               cmd_i,
  output skt_pkg::sts_t               sts_o,
  input  logic [skt_pkg::OP_W-1:0]    opcode_i,
  input  logic [skt_pkg::KEY_W-1:0]   key_i,
  input  logic [skt_pkg::PAY_W-1:0]   payload_i,
  output logic [skt_pkg::ST_W-1:0]    status_o,
  output logic [skt_pkg::PAY_W-1:0]   found_payload_o,
  output logic [skt_pkg::IDX_W-1:0]   found_index_o,
  output logic [skt_pkg::CNT_W-1:0]   entry_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = skt_pkg::KEY_W + skt_pkg::PAY_W;

  logic [EW-1:0] mem [CAPACITY];

  logic [skt_pkg::OP_W-1:0]  op_q;
  logic [skt_pkg::KEY_W-1:0] key_q;
  logic [skt_pkg::PAY_W-1:0] pay_q;
  logic [CW-1:0] lo_q, hi_q, ptr_q, cnt_q;
  logic [EW-1:0] rd_q;

  logic [CW:0]   sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] rd_addr;
  logic          rd_en;
  logic [CW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [skt_pkg::KEY_W-1:0] rd_key;
  logic          go_right;
  logic          res_ok;

  assign sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = sum[CW:1];
  assign rd_key = rd_q[EW-1 -: skt_pkg::KEY_W];

  assign sts_o.is_ins    = (op_q == skt_pkg::OP_INSERT);
  assign sts_o.is_del    = (op_q == skt_pkg::OP_DELETE);
  assign sts_o.is_lkp    = (op_q == skt_pkg::OP_LOOKUP);
  assign sts_o.full      = (cnt_q == CW'(CAPACITY));
  assign sts_o.srch_done = (lo_q == hi_q);
  assign sts_o.pos_valid = (lo_q < cnt_q);
  assign sts_o.hit       = (rd_key == key_q);
  assign sts_o.sh_more   = sts_o.is_ins ? (ptr_q > lo_q)
                                        : ((CW + 1)'(ptr_q) + 1'b1 < {1'b0, cnt_q});

  // Insert uses an upper bound (equal keys stay left); the others a lower bound.
  assign go_right = sts_o.is_ins ? (rd_key <= key_q) : (rd_key < key_q);

  always_comb begin
    rd_en = cmd_i.rd_mid | cmd_i.rd_pos | cmd_i.rd_src;
    if (cmd_i.rd_mid) begin
      rd_addr = mid;
    end else if (cmd_i.rd_pos) begin
      rd_addr = lo_q;
    end else if (sts_o.is_ins) begin
      rd_addr = ptr_q - 1'b1;
    end else begin
      rd_addr = ptr_q + 1'b1;
    end
    wr_addr = cmd_i.wr_new ? lo_q : ptr_q;
    wr_data = cmd_i.wr_new ? {key_q, pay_q} : rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
    if (cmd_i.wr_new || cmd_i.wr_shift) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
  end

  assign res_ok = (cmd_i.fin_status == skt_pkg::ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      ptr_q <= '0;
      cnt_q <= '0;
      status_o        <= skt_pkg::ST_OK;
      found_payload_o <= '0;
      found_index_o   <= '0;
      entry_count_o   <= '0;
    end else begin
      if (cmd_i.load) begin
        lo_q <= '0;
        hi_q <= cnt_q;
      end else if (cmd_i.step) begin
        if (go_right) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q <= mid;
        end
      end
      if (cmd_i.sh_init) begin
        ptr_q <= sts_o.is_ins ? cnt_q : lo_q;
      end else if (cmd_i.wr_shift) begin
        ptr_q <= sts_o.is_ins ? ptr_q - 1'b1 : ptr_q + 1'b1;
      end
      if (cmd_i.fin) begin
        status_o        <= cmd_i.fin_status;
        found_payload_o <= (res_ok && sts_o.is_lkp) ? rd_q[skt_pkg::PAY_W-1:0] : '0;
        found_index_o   <= (res_ok && (sts_o.is_ins || sts_o.is_del || sts_o.is_lkp))
                           ? skt_pkg::IDX_W'(lo_q) : '0;
        if (res_ok && sts_o.is_ins) begin
          cnt_q         <= cnt_q + 1'b1;
          entry_count_o <= skt_pkg::CNT_W'(cnt_q + 1'b1);
        end else if (res_ok && sts_o.is_del) begin
          cnt_q         <= cnt_q - 1'b1;
          entry_count_o <= skt_pkg::CNT_W'(cnt_q - 1'b1);
        end else begin
          entry_count_o <= skt_pkg::CNT_W'(cnt_q);
        end
      end
    end
  end

endmodule

[rtl/skt_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the sorted key table: sequences search, check, shift and
// result steps, and owns both handshakes. Depends on skt_pkg.
module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  skt_pkg::sts_t sts_i,
  output skt_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_CMP, S_CHK, S_SH, S_SHW, S_FIN
  } state_e;

  state_e                   state_q, state_d;
  logic [skt_pkg::ST_W-1:0] stat_q, stat_d;
  logic                     slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_o || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    cmd_o.fin_status = stat_q;
    state_d = state_q;
    stat_d  = stat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (!(sts_i.is_ins || sts_i.is_del || sts_i.is_lkp)) begin
          stat_d  = skt_pkg::ST_OK;
          state_d = S_FIN;
        end else if (sts_i.is_ins && sts_i.full) begin
          stat_d  = skt_pkg::ST_FULL;
          state_d = S_FIN;
        end else if (!sts_i.srch_done) begin
          cmd_o.rd_mid = 1'b1;
          state_d = S_CMP;
        end else if (sts_i.is_ins) begin
          cmd_o.sh_init = 1'b1;
          state_d = S_SH;
        end else if (sts_i.pos_valid) begin
          cmd_o.rd_pos = 1'b1;
          state_d = S_CHK;
        end else begin
          stat_d  = skt_pkg::ST_MISS;
          state_d = S_FIN;
        end
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d = S_SRCH;
      end
      S_CHK: begin
        if (!sts_i.hit) begin
          stat_d  = skt_pkg::ST_MISS;
          state_d = S_FIN;
        end else if (sts_i.is_del) begin
          cmd_o.sh_init = 1'b1;
          state_d = S_SH;
        end else begin
          stat_d  = skt_pkg::ST_OK;
          state_d = S_FIN;
        end
      end
      S_SH: begin
        if (sts_i.sh_more) begin
          cmd_o.rd_src = 1'b1;
          state_d = S_SHW;
        end else begin
          cmd_o.wr_new = sts_i.is_ins;
          stat_d  = skt_pkg::ST_OK;
          state_d = S_FIN;
        end
      end
      S_SHW: begin
        cmd_o.wr_shift = 1'b1;
        state_d = S_SH;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stat_q      <= skt_pkg::ST_OK;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
      if (cmd_o.fin) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

[dv/skt_checker.sv]
`timescale 1ns / 1ps
// Checker for the sorted key table: watches both channels, keeps its own copy
// of the ordered entries, predicts each result and compares. Depends on skt_pkg.
module skt_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [skt_pkg::OP_W-1:0]  opcode_i,
  input  logic [skt_pkg::KEY_W-1:0] key_i,
  input  logic [skt_pkg::PAY_W-1:0] payload_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [skt_pkg::ST_W-1:0]  status_i,
  input  logic [skt_pkg::PAY_W-1:0] found_payload_i,
  input  logic [skt_pkg::IDX_W-1:0] found_index_i,
  input  logic [skt_pkg::CNT_W-1:0] entry_count_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int DEPTH = skt_pkg::DEF_CAPACITY;

  typedef struct packed {
    logic [skt_pkg::ST_W-1:0]  status;
    logic [skt_pkg::PAY_W-1:0] pay;
    logic [skt_pkg::IDX_W-1:0] idx;
    logic [skt_pkg::CNT_W-1:0] cnt;
  } table_result_t;

  logic [skt_pkg::KEY_W-1:0] model_keys [DEPTH];
  logic [skt_pkg::PAY_W-1:0] model_pays [DEPTH];
  int                        model_count;
  table_result_t             result_queue [$];

  assign pending_o = result_queue.size();

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count_o++;
  endtask

  // First position whose key is >= k, or > k when past_equal is set.
  function automatic int find_pos(input logic [skt_pkg::KEY_W-1:0] k,
                                  input bit past_equal);
    int i;
    for (i = 0; i < model_count; i++) begin
      if (past_equal ? (model_keys[i] > k) : (model_keys[i] >= k)) return i;
    end
    return model_count;
  endfunction

  task automatic apply_operation(input logic [skt_pkg::OP_W-1:0] op,
                                 input logic [skt_pkg::KEY_W-1:0] k,
                                 input logic [skt_pkg::PAY_W-1:0] p);
    table_result_t r;
    int pos;
    r = '0;
    case (op)
      skt_pkg::OP_INSERT: begin
        if (model_count >= DEPTH) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          pos = find_pos(k, 1'b1);
          for (int i = model_count; i > pos; i--) begin
            model_keys[i] = model_keys[i-1];
            model_pays[i] = model_pays[i-1];
          end
          model_keys[pos] = k;
          model_pays[pos] = p;
          model_count++;
          r.idx = pos[skt_pkg::IDX_W-1:0];
        end
      end
      skt_pkg::OP_DELETE, skt_pkg::OP_LOOKUP: begin
        pos = find_pos(k, 1'b0);
        if (pos < model_count && model_keys[pos] == k) begin
          r.idx = pos[skt_pkg::IDX_W-1:0];
          if (op == skt_pkg::OP_LOOKUP) begin
            r.pay = model_pays[pos];
          end else begin
            for (int i = pos; i + 1 < model_count; i++) begin
              model_keys[i] = model_keys[i+1];
              model_pays[i] = model_pays[i+1];
            end
            model_count--;
          end
        end else begin
          r.status = skt_pkg::ST_MISS;
        end
      end
      default: ;
    endcase
    r.cnt = model_count[skt_pkg::CNT_W-1:0];
    result_queue.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t e;
    if (!rst_ni) begin
      model_count = 0;
      result_queue.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_queue.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = result_queue.pop_front();
          if (status_i !== e.status)
            report_mismatch($sformatf("status %0d want %0d", status_i, e.status));
          if (found_payload_i !== e.pay)
            report_mismatch($sformatf("payload %h want %h", found_payload_i, e.pay));
          if (found_index_i !== e.idx)
            report_mismatch($sformatf("index %0d want %0d", found_index_i, e.idx));
          if (entry_count_i !== e.cnt)
            report_mismatch($sformatf("count %0d want %0d", entry_count_i, e.cnt));
        end
      end
      if (in_valid_i && !in_stall_i) apply_operation(opcode_i, key_i, payload_i);
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the sorted key table testbench: clock, reset, stimulus and verdict.
// Depends on skt_pkg, sorted_key_table and skt_checker.
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [skt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [skt_pkg::OP_W-1:0]  opcode = skt_pkg::OP_INSERT;
  logic [skt_pkg::KEY_W-1:0] key = '0;
  logic [skt_pkg::PAY_W-1:0] payload = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [skt_pkg::ST_W-1:0]  status;
  logic [skt_pkg::PAY_W-1:0] found_payload;
  logic [skt_pkg::IDX_W-1:0] found_index;
  logic [skt_pkg::CNT_W-1:0] entry_count;
  int                        fail_count;
  int                        pending;
  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  int                        idle_cycles = 0;
  logic [skt_pkg::KEY_W-1:0] used_keys [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_key_table i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .key_i(key), .payload_i(payload),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .found_payload_o(found_payload),
    .found_index_o(found_index), .entry_count_o(entry_count)
  );

  skt_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .key_i(key), .payload_i(payload),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .found_payload_i(found_payload),
    .found_index_i(found_index), .entry_count_i(entry_count),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog on cycles with no accepted transaction and no result taken.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[sorted_key_table] ERROR");
      $finish;
    end
  end

  // Holds one transaction until accepted, after an optional random gap.
  // Returns at the falling edge after acceptance with valid still high; the
  // next call or wait_drained decides what valid does from there.
  task automatic send_op(input logic [skt_pkg::OP_W-1:0] op,
                         input logic [skt_pkg::KEY_W-1:0] k,
                         input logic [skt_pkg::PAY_W-1:0] p);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    payload <= p;
    // The stall seen at the falling edge holds through the next rising edge.
    do begin
      stalled = in_stall;
      @(posedge clk_i);
      @(negedge clk_i);
    end while (stalled);
    if (op == skt_pkg::OP_INSERT) used_keys.push_back(k);
  endtask

  // Mostly reuses keys already seen so deletes and lookups hit.
  function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(99) < 70)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return '1 - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int phase_ops;
    logic [skt_pkg::OP_W-1:0] op;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, key extremes, duplicates, full table, unused opcode.
    send_op(skt_pkg::OP_LOOKUP, 32'd5, '1);
    send_op(skt_pkg::OP_DELETE, 32'd5, '0);
    send_op(skt_pkg::OP_INSERT, '1, '1);
    send_op(skt_pkg::OP_INSERT, '0, 32'h0000_0001);
    send_op(skt_pkg::OP_INSERT, 32'd7, 32'haaaa_5555);
    send_op(skt_pkg::OP_INSERT, 32'd7, 32'h5555_aaaa);
    send_op(skt_pkg::OP_LOOKUP, 32'd7, '0);
    send_op(skt_pkg::OP_LOOKUP, '1, '0);
    send_op(skt_pkg::OP_LOOKUP, 32'd8, '0);
    send_op(skt_pkg::OP_DELETE, 32'd7, '0);
    send_op(skt_pkg::OP_LOOKUP, 32'd7, '0);
    send_op(OP_UNUSED, 32'd7, '1);
    send_op(skt_pkg::OP_DELETE, '0, '0);
    send_op(skt_pkg::OP_DELETE, '1, '0);
    send_op(skt_pkg::OP_DELETE, 32'd7, '0);
    for (int i = 0; i < 66; i++) send_op(skt_pkg::OP_INSERT, $urandom_range(40), $urandom);
    send_op(skt_pkg::OP_LOOKUP, 32'd20, '0);
    wait_drained();
    for (int i = 0; i < 66; i++) send_op(skt_pkg::OP_DELETE, $urandom_range(40), '0);

    // Random phases: none, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 2) ? ((phase == 1) ? 81 : 0) : 0;
      stall_pct = (phase == 2) ? 81 : 0;
      if (phase == 3) begin
        send_idle_pct = 19;
        stall_pct = 19;
      end
      phase_ops = 290;
      for (int n = 0; n < phase_ops; n++) begin
        // Bias toward fill in the first half of each phase, drain in the second.
        case ($urandom_range(9))
          0, 1, 2, 3: op = (n < phase_ops / 2) ? skt_pkg::OP_INSERT : skt_pkg::OP_DELETE;
          4, 5: op = skt_pkg::OP_INSERT;
          6: op = skt_pkg::OP_DELETE;
          7, 8: op = skt_pkg::OP_LOOKUP;
          default: op = OP_UNUSED;
        endcase
        send_op(op, pick_key(), $urandom);
      end
      wait_drained();
    end

    wait_drained();
    repeat (600) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[sorted_key_table] OK");
    end else begin
      $display("[sorted_key_table] ERROR");
    end
    $finish;
  end
endmodule

[files.f]
rtl/skt_pkg.sv
rtl/skt_dp.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
dv/skt_checker.sv
dv/testbench.sv
